FILE: design/rse_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// rse_pkg
// Shared types, sizes and helper functions for the rANS symbol encoder.
// ============================================================================
package rse_pkg;

    // Coder sizing
    localparam int L_BITS     = 23;
    localparam int PROB_BITS  = 12;
    localparam int DIGIT_BITS = 8;

    localparam int STATE_W    = L_BITS + DIGIT_BITS;
    localparam int FREQ_W     = PROB_BITS + 1;
    localparam int REM_W      = PROB_BITS + 2;
    localparam int MAX_DIGITS = 4;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int STEP_W     = $clog2(STATE_W);

    // Fixed field widths of the beats
    localparam int REQ_W    = 3;
    localparam int START_W  = 12;
    localparam int SFREQ_W  = 13;
    localparam int EXTRA_W  = 31;
    localparam int DIGIT_W  = 8;

    // Derived widths and shifts
    localparam int BND_SH  = (L_BITS >= PROB_BITS) ? L_BITS - PROB_BITS + DIGIT_BITS : 0;
    localparam int PRB_SH  = (L_BITS >= PROB_BITS) ? L_BITS - PROB_BITS : 0;
    localparam int CMP_W   = (FREQ_W + BND_SH > STATE_W) ? FREQ_W + BND_SH : STATE_W;
    localparam int SUM_W   = ((STATE_W > EXTRA_W) ? STATE_W : EXTRA_W) + 1;
    localparam int FIN_W   = STATE_W + PROB_BITS + 2;

    localparam logic [STATE_W-1:0] LOW_BOUND = {{(STATE_W-1){1'b0}}, 1'b1} << L_BITS;
    localparam logic [STATE_W-1:0] STATE_MAX = {STATE_W{1'b1}};
    localparam logic [FREQ_W-1:0]  PROB_TOTAL = {{(FREQ_W-1){1'b0}}, 1'b1} << PROB_BITS;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ENCODE    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_FLUSH     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INIT_L    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_INIT_ZERO = 3'd3;
    localparam logic [REQ_W-1:0] REQ_INIT_PROB = 3'd4;
    localparam logic [REQ_W-1:0] REQ_ADD_EXTRA = 3'd5;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [START_W-1:0] sym_start;
        logic [SFREQ_W-1:0] sym_freq;
        logic [EXTRA_W-1:0] extra_value;
    } t_in_item;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               last_digit;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic emit;
        logic last;
        logic div_init;
        logic div_step;
        logic div_finish;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic more;
        logic more_after;
        logic out_free;
        logic is_encode;
    } t_status;

    // Clamp frequency into 1..M
    function automatic logic [FREQ_W-1:0] clamp_freq(input logic [SFREQ_W-1:0] f);
        logic [FREQ_W-1:0] r;
        if (f == '0) begin
            r = {{(FREQ_W-1){1'b0}}, 1'b1};
        end else if (SFREQ_W'(f) > SFREQ_W'(PROB_TOTAL)) begin
            r = PROB_TOTAL;
        end else begin
            r = FREQ_W'(f);
        end
        return r;
    endfunction

    // State at or above the renormalization bound for this frequency
    function automatic logic above_bound(input logic [STATE_W-1:0] s,
                                         input logic [FREQ_W-1:0]  f);
        logic [CMP_W-1:0] b;
        b = CMP_W'(f) << BND_SH;
        if (L_BITS < PROB_BITS) begin
            return 1'b1;
        end
        return CMP_W'(s) >= b;
    endfunction

    // (L / M) * freq
    function automatic logic [STATE_W-1:0] prob_init(input logic [FREQ_W-1:0] f);
        logic [STATE_W-1:0] v;
        v = STATE_W'(f) << PRB_SH;
        if (L_BITS < PROB_BITS) begin
            v = '0;
        end
        return v;
    endfunction

    function automatic logic [DIGIT_W-1:0] digit_of(input logic [STATE_W-1:0] s);
        logic [DIGIT_BITS-1:0] d;
        d = s[DIGIT_BITS-1:0];
        return DIGIT_W'(d);
    endfunction

endpackage

FILE: design/rse_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// rse_ctrl
// Request sequencer: digit emission, division steps and state write-back.
// ============================================================================
module rse_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic [rse_pkg::REQ_W-1:0] i_req_type,
    input  rse_pkg::t_status      i_status,
    output logic                  o_in_ready,
    output rse_pkg::t_cmd         o_cmd
);
    import rse_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EMIT,
        S_DIV,
        S_FINISH
    } t_ctl_state;

    t_ctl_state        r_fsm, n_fsm;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [STEP_W-1:0] r_step, n_step;

    always_comb begin
        n_fsm  = r_fsm;
        n_cnt  = r_cnt;
        n_step = r_step;
        o_cmd  = '0;
        o_in_ready = 1'b0;
        unique case (r_fsm)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt = '0;
                    if (i_req_type == REQ_ENCODE || i_req_type == REQ_FLUSH) begin
                        n_fsm = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (r_cnt < CNT_W'(MAX_DIGITS) && i_status.more) begin
                    if (i_status.out_free) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.last = !((r_cnt + 1'b1) < CNT_W'(MAX_DIGITS)
                                       && i_status.more_after);
                        n_cnt = r_cnt + 1'b1;
                    end
                end else if (i_status.is_encode) begin
                    o_cmd.div_init = 1'b1;
                    n_step = '0;
                    n_fsm  = S_DIV;
                end else begin
                    n_fsm = S_IDLE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(STATE_W - 1)) begin
                    n_fsm = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.div_finish = 1'b1;
                n_fsm = S_IDLE;
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm  <= S_IDLE;
            r_cnt  <= '0;
            r_step <= '0;
        end else begin
            r_fsm  <= n_fsm;
            r_cnt  <= n_cnt;
            r_step <= n_step;
        end
    end

endmodule

FILE: design/rse_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// rse_datapath
// Coder state, radix-2 restoring divider and the output beat register.
// ============================================================================
module rse_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rse_pkg::t_in_item  i_in_data,
    input  rse_pkg::t_cmd      i_cmd,
    input  logic               i_out_ready,
    output rse_pkg::t_status   o_status,
    output logic               o_out_valid,
    output rse_pkg::t_out_item o_out_data
);
    import rse_pkg::*;

    logic [STATE_W-1:0] r_state;
    logic [REQ_W-1:0]   r_req;
    logic [FREQ_W-1:0]  r_freq;
    logic [START_W-1:0] r_start;
    logic [STATE_W-1:0] r_quo;
    logic [REM_W-1:0]   r_rem;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [STATE_W-1:0] shifted;
    logic [REM_W-1:0]   rem_sh;
    logic               rem_ge;
    logic [SUM_W-1:0]   add_sum;
    logic [FIN_W-1:0]   fin_sum;
    logic [FREQ_W-1:0]  in_freq;

    assign in_freq = clamp_freq(i_in_data.sym_freq);
    assign shifted = r_state >> DIGIT_BITS;
    assign rem_sh  = {r_rem[REM_W-2:0], r_quo[STATE_W-1]};
    assign rem_ge  = rem_sh >= REM_W'(r_freq);
    assign add_sum = SUM_W'(r_state) + SUM_W'(i_in_data.extra_value);
    assign fin_sum = (FIN_W'(r_quo) << PROB_BITS) + FIN_W'(r_start) + FIN_W'(r_rem);

    assign o_status.more       = (r_state != '0)
                               && (r_req == REQ_FLUSH || above_bound(r_state, r_freq));
    assign o_status.more_after = (shifted != '0)
                               && (r_req == REQ_FLUSH || above_bound(shifted, r_freq));
    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_status.is_encode  = (r_req == REQ_ENCODE);

    // Coder state and request registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LOW_BOUND;
        end else if (i_cmd.load) begin
            case (i_in_data.req_type)
                REQ_INIT_L:    r_state <= LOW_BOUND;
                REQ_INIT_ZERO: r_state <= '0;
                REQ_INIT_PROB: r_state <= prob_init(in_freq);
                REQ_ADD_EXTRA: begin
                    r_state <= (add_sum > SUM_W'(STATE_MAX)) ? STATE_MAX
                                                             : STATE_W'(add_sum);
                end
                default: r_state <= r_state;
            endcase
        end else if (i_cmd.emit) begin
            r_state <= shifted;
        end else if (i_cmd.div_finish) begin
            r_state <= (fin_sum > FIN_W'(STATE_MAX)) ? STATE_MAX : STATE_W'(fin_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req   <= i_in_data.req_type;
            r_freq  <= in_freq;
            r_start <= i_in_data.sym_start;
        end
    end

    // Divider: shift dividend bits into the partial remainder
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_quo <= r_state;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[STATE_W-2:0], rem_ge};
            r_rem <= rem_ge ? rem_sh - REM_W'(r_freq) : rem_sh;
        end
    end

    // Output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.digit      <= digit_of(r_state);
            r_out.last_digit <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: design/rans_symbol_encoder_core.sv
`timescale 1ns / 1ps
// ============================================================================
// rans_symbol_encoder_core
// rANS encoder with a single coder state word and a digit output stream.
// ============================================================================
// Each input beat is one request. Encode renormalizes the state by emitting
// its low digits (lowest first, at most four per request) and then folds the
// symbol in through a radix-2 restoring divider that takes one state bit per
// cycle; flush emits digits until the state is zero or four have gone out;
// the init and add-extra requests update the state in the cycle the beat is
// accepted. After acceptance, init, add-extra and the unused codes return
// straight to idle; a flush runs its digit emissions; an encode runs its
// digit emissions, one setup step, one divider step per bit of the 31-bit
// state and one write-back step. Digit emission also waits while the
// output register still holds an untaken beat. The output register
// decouples the two sides, so a new request is taken while the last digit
// of the previous one still waits downstream.
// ============================================================================
module rans_symbol_encoder_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rse_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rse_pkg::t_out_item o_out_data
);
    import rse_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequence requests
    rse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_data.req_type),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // Hold state, divide, and register the outgoing digit beat
    rse_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: design/rse_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// rse_checker
// Port-level checks for the rANS encoder, bound to the top level.
// ============================================================================
module rse_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input rse_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input rse_pkg::t_out_item o_out_data
);
    import rse_pkg::*;

    // Hold a stalled output beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    // Requests other than encode and flush finish in the accept cycle
    a_quick_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.req_type != REQ_ENCODE
        && i_in_data.req_type != REQ_FLUSH |=> o_in_ready)
        else $error("non-emitting request held the input");

    // Encode always runs the divider
    a_encode_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.req_type == REQ_ENCODE |=> !o_in_ready)
        else $error("encode request did not occupy the block");

endmodule

bind rans_symbol_encoder_core rse_checker u_rse_checker (.*);

FILE: sim/tb_rans_symbol_encoder_core.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_rans_symbol_encoder_core
// Self-checking bench for the rANS symbol encoder core.
// ============================================================================
// Feed request beats from a queue through a valid/ready driver and check
// every digit beat against a cycle-free model of the coder state. Start with
// a directed set (field extremes, every request code, clamped frequencies,
// saturation, the unused codes). Then run random traffic, mostly well-formed
// symbol runs, in four idling phases: none, sender idle, receiver stalling,
// and both. Drain all digits between phases, so the sender sits out until
// the output side is empty at least once per phase.
// ============================================================================
module tb_rans_symbol_encoder_core;
    import rse_pkg::*;

    // Unused request codes: the core must ignore them
    localparam logic [REQ_W-1:0] REQ_RSVD_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD_7 = 3'd7;

    // Coder constants in 64-bit form for the model arithmetic
    localparam longint unsigned LOW_V    = 64'd1 << L_BITS;
    localparam longint unsigned TOTAL_V  = 64'd1 << PROB_BITS;
    localparam longint unsigned DMASK_V  = (64'd1 << DIGIT_BITS) - 64'd1;
    localparam longint unsigned SMAX_V   = (64'd1 << (L_BITS + DIGIT_BITS)) - 64'd1;

    localparam int PHASE_ITEMS = 55;
    localparam int SETTLE_CYC  = 80;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    t_in_item   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_data;

    // Model of the coder state word, reset value L
    longint unsigned coder_state_m = LOW_V;

    t_in_item   request_q[$];     // requests not yet offered to the core
    t_out_item  pending_digits[$]; // digits the core still owes us

    int idle_pct  = 0;
    int stall_pct = 0;
    int in_sent_cnt  = 0;
    int in_taken_cnt = 0;
    int digit_cnt = 0;
    int err_count = 0;

    rans_symbol_encoder_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Apply one accepted request to the model state and queue the digits it
    // emits. Flush is renormalization against a zero bound: it runs until the
    // state is empty. Both stop at the per-request digit cap.
    task automatic apply_request(input t_in_item rq);
        longint unsigned s;
        longint unsigned f;
        longint unsigned bound;
        longint unsigned q;
        longint unsigned r;
        longint unsigned nx;
        t_out_item       emitted[MAX_DIGITS];
        int              n;
        s = coder_state_m;
        n = 0;
        // Frequency zero counts as one, anything above M as M
        f = 64'(rq.sym_freq);
        if (f == 0) begin
            f = 1;
        end else if (f > TOTAL_V) begin
            f = TOTAL_V;
        end
        case (rq.req_type) inside
            REQ_ENCODE, REQ_FLUSH: begin
                bound = (rq.req_type == REQ_ENCODE) ?
                        ((LOW_V >> PROB_BITS) << DIGIT_BITS) * f : 64'd0;
                while (n < MAX_DIGITS && s != 0 && s >= bound) begin
                    emitted[n].digit      = DIGIT_W'(s & DMASK_V);
                    emitted[n].last_digit = 1'b0;
                    s = s >> DIGIT_BITS;
                    n++;
                end
                if (rq.req_type == REQ_ENCODE) begin
                    q = s / f;
                    r = s % f;
                    // Inconsistent start/frequency pairs saturate the state
                    if (q > (SMAX_V >> PROB_BITS)) begin
                        s = SMAX_V;
                    end else begin
                        nx = (q << PROB_BITS) + 64'(rq.sym_start) + r;
                        s = (nx > SMAX_V) ? SMAX_V : nx;
                    end
                end
            end
            REQ_INIT_L: begin
                s = LOW_V;
            end
            REQ_INIT_ZERO: begin
                s = 0;
            end
            REQ_INIT_PROB: begin
                s = (LOW_V >> PROB_BITS) * f;
                if (s > SMAX_V) begin
                    s = SMAX_V;
                end
            end
            REQ_ADD_EXTRA: begin
                s = s + 64'(rq.extra_value);
                if (s > SMAX_V) begin
                    s = SMAX_V;
                end
            end
            default: begin
            end
        endcase
        coder_state_m = s;
        for (int k = 0; k < n; k++) begin
            emitted[k].last_digit = (k == n - 1);
            pending_digits.push_back(emitted[k]);
        end
    endtask

    function automatic t_in_item mk_req(input logic [REQ_W-1:0]   rt,
                                        input logic [START_W-1:0] st,
                                        input logic [SFREQ_W-1:0] fq,
                                        input logic [EXTRA_W-1:0] ex);
        t_in_item rq;
        rq.req_type    = rt;
        rq.sym_start   = st;
        rq.sym_freq    = fq;
        rq.extra_value = ex;
        return rq;
    endfunction

    // Random request: mostly consistent symbol encodes so the state walks
    // through real coding runs, with flushes and re-inits mixed in, and a
    // tail of malformed pairs, odd frequencies and unused codes.
    function automatic t_in_item rand_request();
        t_in_item    rq;
        int          pick;
        int unsigned fq;
        rq.req_type    = REQ_ENCODE;
        rq.sym_start   = START_W'($urandom);
        rq.sym_freq    = SFREQ_W'($urandom);
        rq.extra_value = EXTRA_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 56) begin
            fq = ($urandom_range(3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4096);
            rq.sym_freq  = SFREQ_W'(fq);
            rq.sym_start = START_W'($urandom_range(0, 4096 - fq));
        end else if (pick < 65) begin
            rq.req_type = REQ_FLUSH;
        end else if (pick < 70) begin
            rq.req_type = REQ_INIT_L;
        end else if (pick < 73) begin
            rq.req_type = REQ_INIT_ZERO;
        end else if (pick < 79) begin
            rq.req_type = REQ_INIT_PROB;
        end else if (pick < 85) begin
            rq.req_type = REQ_ADD_EXTRA;
            if ($urandom_range(1) == 0) begin
                rq.extra_value = EXTRA_W'($urandom_range(0, 1 << 20));
            end
        end else if (pick < 94) begin
            // Malformed encode: any start with any 13-bit frequency
            if ($urandom_range(3) == 0) begin
                rq.sym_freq = '0;
            end
        end else begin
            rq.req_type = pick[0] ? REQ_RSVD_7 : REQ_RSVD_6;
        end
        return rq;
    endfunction

    // Driver: change inputs on the falling edge. Hold the beat until taken,
    // then offer the next one or idle.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= stall_pct);
            if (in_sent_cnt == in_taken_cnt) begin
                if (request_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    in_data  <= request_q.pop_front();
                    in_valid <= 1'b1;
                    in_sent_cnt++;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: on the rising edge, advance the model for every accepted
    // request beat, then check every digit beat against the oldest owed one.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (in_valid && in_ready) begin
                apply_request(in_data);
                in_taken_cnt++;
            end
            if (out_valid && out_ready) begin
                digit_cnt++;
                if (pending_digits.size() == 0) begin
                    $display("%0t: unexpected digit beat, expected none, got digit %0h last %0b",
                             $time, out_data.digit, out_data.last_digit);
                    err_count++;
                end else begin
                    want = pending_digits.pop_front();
                    if (out_data.digit !== want.digit) begin
                        $display("%0t: digit mismatch, expected %0h, got %0h",
                                 $time, want.digit, out_data.digit);
                        err_count++;
                    end
                    if (out_data.last_digit !== want.last_digit) begin
                        $display("%0t: last_digit mismatch, expected %0b, got %0b",
                                 $time, want.last_digit, out_data.last_digit);
                        err_count++;
                    end
                end
            end
        end
    end

    // Wait until every queued request is taken and every owed digit is out
    task automatic drain();
        while (request_q.size() > 0 || in_sent_cnt != in_taken_cnt ||
               pending_digits.size() > 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        int n;
        t_in_item rq;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed set, no idling
        request_q.push_back(mk_req(REQ_ENCODE, 12'd0, 13'd1, '0));
        request_q.push_back(mk_req(REQ_ENCODE, 12'd4095, 13'd1, '0));
        request_q.push_back(mk_req(REQ_FLUSH, '0, '0, '0));
        request_q.push_back(mk_req(REQ_FLUSH, 12'hfff, 13'h1fff, 31'h7fffffff));
        request_q.push_back(mk_req(REQ_ENCODE, 12'd0, 13'd4096, '0));
        request_q.push_back(mk_req(REQ_INIT_L, '0, '0, '0));
        request_q.push_back(mk_req(REQ_ENCODE, 12'd0, 13'd0, '0));
        request_q.push_back(mk_req(REQ_ENCODE, 12'd100, 13'h1fff, '0));
        request_q.push_back(mk_req(REQ_INIT_PROB, '0, 13'd4096, '0));
        request_q.push_back(mk_req(REQ_ENCODE, 12'd2048, 13'd2048, '0));
        request_q.push_back(mk_req(REQ_INIT_PROB, '0, 13'd0, '0));
        request_q.push_back(mk_req(REQ_FLUSH, '0, '0, '0));
        request_q.push_back(mk_req(REQ_INIT_PROB, '0, 13'h1fff, '0));
        request_q.push_back(mk_req(REQ_ADD_EXTRA, '0, '0, 31'h7fffffff));
        // Saturated state with a start/frequency pair that overflows
        request_q.push_back(mk_req(REQ_ENCODE, 12'd4095, 13'd4096, '0));
        request_q.push_back(mk_req(REQ_ADD_EXTRA, '0, '0, 31'h7fffffff));
        request_q.push_back(mk_req(REQ_ENCODE, 12'd4095, 13'd1, '0));
        request_q.push_back(mk_req(REQ_RSVD_6, 12'hfff, 13'h1fff, 31'h7fffffff));
        request_q.push_back(mk_req(REQ_RSVD_7, 12'h555, 13'h0aaa, 31'h2aaaaaaa));
        request_q.push_back(mk_req(REQ_INIT_ZERO, '0, '0, '0));
        request_q.push_back(mk_req(REQ_ENCODE, 12'd7, 13'd9, '0));
        request_q.push_back(mk_req(REQ_ADD_EXTRA, '0, '0, 31'd1));
        request_q.push_back(mk_req(REQ_FLUSH, '0, '0, '0));
        request_q.push_back(mk_req(REQ_INIT_L, '0, '0, '0));
        drain();

        // Random traffic in four idling phases; drain between phases
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1) ? 68 : (ph == 3) ? 24 : 0;
            stall_pct = (ph == 2) ? 68 : (ph == 3) ? 24 : 0;
            n = 0;
            while (n < PHASE_ITEMS) begin
                rq = rand_request();
                request_q.push_back(rq);
                if (rq.req_type != REQ_RSVD_6 && rq.req_type != REQ_RSVD_7) begin
                    n++;
                end
            end
            drain();
        end

        // Let any stray beat show up before judging
        repeat (SETTLE_CYC) @(posedge i_clk);
        $display("Covered %0d request beats (directed set plus four idling phases),",
                 in_taken_cnt);
        $display("%0d digit beats checked.", digit_cnt);
        if (err_count == 0 && pending_digits.size() == 0) begin
            $display("tb_rans_symbol_encoder_core passed");
        end else begin
            $display("%0d errors, %0d digits never arrived", err_count, pending_digits.size());
            $display("tb_rans_symbol_encoder_core failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #2000000;
        $display("Timeout with %0d digits still owed", pending_digits.size());
        $display("tb_rans_symbol_encoder_core failed");
        $finish;
    end

endmodule
